// ----- sv/bsfp_pkg.sv -----
package bsfp_pkg;

    // FIFO geometry. Pointers wrap from FIFO_BYTES-1 back to zero.
    localparam int FIFO_BYTES = 64;
    localparam int PTR_W      = $clog2(FIFO_BYTES);
    localparam int CNT_W      = $clog2(FIFO_BYTES + 1);

    // Fixed field widths of the bus words.
    localparam int DATA_W     = 64;
    localparam int FILL_W     = 7;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 72;

    // Access kinds.
    localparam logic [1:0] OP_STREAM_WR = 2'd0;
    localparam logic [1:0] OP_STREAM_RD = 2'd1;
    localparam logic [1:0] OP_STATUS_RD = 2'd2;
    localparam logic [1:0] OP_STATUS_WR = 2'd3;

    // Result codes.
    localparam logic [1:0] RES_DONE     = 2'd0;
    localparam logic [1:0] RES_UNDERRUN = 2'd1;
    localparam logic [1:0] RES_OVERRUN  = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       set_outcome;
        logic [1:0] outcome;
        logic       push;
        logic       pop;
        logic       finish;
    } bsfp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       fits;
        logic       enough;
        logic       last;
        logic       out_free;
    } bsfp_status_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_BYTES - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    // Keeps the low access-size bytes and, for a big-endian guest, reverses them
    // within the access size.
    function automatic logic [DATA_W-1:0] guest_order(input logic [DATA_W-1:0] v,
                                                      input logic [1:0]        sc,
                                                      input logic              be);
        logic [DATA_W-1:0] r;
        logic [3:0]        n;
        logic [2:0]        j;
        r = '0;
        n = 4'd1 << sc;
        for (int i = 0; i < 8; i++)
        begin
            j = 3'(n - 4'd1 - 4'(i));
            if (4'(i) < n)
            begin
                if (be)
                    r[{j, 3'b000} +: 8] = v[8*i +: 8];
                else
                    r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/bsfp_ctrl.sv -----
module bsfp_ctrl
    import bsfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  bsfp_status_t sts,
    output bsfp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_POP  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.set_outcome = 1'b1;
                cmd.outcome     = RES_DONE;
                state_next      = ST_DONE;
                case (sts.op)
                    OP_STREAM_WR:
                    begin
                        if (sts.fits)
                            state_next = ST_PUSH;
                        else
                            cmd.outcome = RES_OVERRUN;
                    end
                    OP_STREAM_RD:
                    begin
                        if (sts.enough)
                            state_next = ST_POP;
                        else
                            cmd.outcome = RES_UNDERRUN;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (sts.last)
                    state_next = ST_DONE;
            end
            ST_POP:
            begin
                cmd.pop = 1'b1;
                if (sts.last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/bsfp_dp.sv -----
module bsfp_dp
    import bsfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsfp_cmd_t         cmd,
    output bsfp_status_t      sts,
    input  logic [1:0]        in_op,
    input  logic [1:0]        in_size,
    input  logic [DATA_W-1:0] in_wdata,
    input  logic              cfg_we,
    input  logic              cfg_be,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_rdata,
    output logic [1:0]        out_outcome,
    output logic [FILL_W-1:0] out_fill
);

    logic [7:0]        mem [FIFO_BYTES];

    logic              be_reg;
    logic [1:0]        op_reg;
    logic [1:0]        size_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [2:0]        idx_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  tail_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [1:0]        outcome_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_rdata_reg;
    logic [1:0]        out_outcome_reg;
    logic [FILL_W-1:0] out_fill_reg;

    logic [3:0]        nbytes;
    logic [DATA_W-1:0] src;

    assign nbytes = 4'd1 << size_reg;

    assign sts.op       = op_reg;
    assign sts.fits     = ((CNT_W+1)'(count_reg) + (CNT_W+1)'(nbytes))
                          <= (CNT_W+1)'(FIFO_BYTES);
    assign sts.enough   = count_reg >= CNT_W'(nbytes);
    assign sts.last     = idx_reg == 3'(nbytes - 4'd1);
    assign sts.out_free = !out_valid_reg || out_ready;

    // Only a stream read takes its value from the assembled bytes; the
    // accumulator is cleared on every new word, so a refused read gives zero.
    always_comb
    begin
        case (op_reg)
            OP_STATUS_RD: src = DATA_W'(count_reg);
            OP_STREAM_RD: src = acc_reg;
            default:      src = '0;
        endcase
    end

    // Byte store, one push or one pop per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[tail_reg] <= wdata_reg[{idx_reg, 3'b000} +: 8];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            acc_reg <= '0;
        else if (cmd.pop)
            acc_reg[{idx_reg, 3'b000} +: 8] <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= in_op;
            size_reg  <= in_size;
            wdata_reg <= in_wdata;
        end
        if (cmd.set_outcome)
            outcome_reg <= cmd.outcome;
        if (cmd.finish)
        begin
            out_rdata_reg   <= guest_order(src, size_reg, be_reg);
            out_outcome_reg <= outcome_reg;
            out_fill_reg    <= FILL_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            be_reg        <= 1'b0;
            idx_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                be_reg <= cfg_be;
            if (cmd.accept)
                idx_reg <= '0;
            else if (cmd.push || cmd.pop)
                idx_reg <= idx_reg + 3'd1;
            if (cmd.push)
            begin
                tail_reg <= ptr_inc(tail_reg);
                if (sts.last)
                    count_reg <= count_reg + CNT_W'(nbytes);
            end
            if (cmd.pop)
            begin
                head_reg <= ptr_inc(head_reg);
                if (sts.last)
                    count_reg <= count_reg - CNT_W'(nbytes);
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_rdata   = out_rdata_reg;
    assign out_outcome = out_outcome_reg;
    assign out_fill    = out_fill_reg;

endmodule

// ----- sv/byte_stream_fifo_port_unit.sv -----
// Byte FIFO behind a bus port that takes accesses of 1, 2, 4 or 8 bytes.
// The slave stream carries one access per word: tuser is the access kind
// (stream write, stream read, status read, status write) and tdata holds the
// size code and the write bytes. The master stream returns one result word
// per access: read data in guest byte order, the fill level, and in tuser a
// code that says whether the access was done or refused as an overrun or
// underrun. A refused access leaves the FIFO untouched.
// The byte store has one port, so a stream access moves one byte per cycle.
// A status or refused access passes from acceptance through the evaluate state
// to the done state, which loads the result register; a stream access of n
// bytes steps through a push or pop state for each byte in between. The next
// word is accepted only after the previous result has been registered.
// The big_endian register is written over the cfg channel, which is always
// ready; write it only while no access is in flight.
// Reset empties the FIFO, clears big_endian and drops m_tvalid. When the
// receiver stalls, the result word holds on the master side, and the block
// may still accept and work on one more access, which then waits for the
// output register to free up before its result is loaded.
module byte_stream_fifo_port_unit
    import bsfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Access words.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // size_code [1:0], write_data [65:2], zero pad
    input  logic [1:0]           s_tuser,   // opcode [1:0]
    // Result words.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // read_data [63:0], fill_level [70:64], zero pad
    output logic [1:0]           m_tuser,   // outcome [1:0]
    // Configuration: big_endian.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    bsfp_cmd_t         cmd;
    bsfp_status_t      sts;
    logic [DATA_W-1:0] rdata;
    logic [FILL_W-1:0] fill;

    assign cfg_ready = 1'b1;

    // The controller sequences each access: it evaluates room or occupancy,
    // steps through the bytes, and hands the result to the output register.
    bsfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the byte store, pointers, count and the result word.
    bsfp_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_op       (s_tuser),
        .in_size     (s_tdata[1:0]),
        .in_wdata    (s_tdata[DATA_W+1:2]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_be      (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_rdata   (rdata),
        .out_outcome (m_tuser),
        .out_fill    (fill)
    );

    assign m_tdata = {(M_TDATA_W - DATA_W - FILL_W)'(0), fill, rdata};

endmodule
